// ===== sv/bezier_de_casteljau_subdivide_assert.svh =====
// Assertion macros for the Bezier subdivision block.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef BEZIER_DE_CASTELJAU_SUBDIVIDE_ASSERT_SVH
`define BEZIER_DE_CASTELJAU_SUBDIVIDE_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define BDC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define BDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== sv/bdc_pkg.sv =====
// Shared types and constants for the Bezier subdivision block.
// Used by bdc_ctrl, bdc_dp and the top level; depends on nothing.
package bdc_pkg;

  localparam int DEG_W      = 4;
  localparam int T_W        = 17;
  localparam int COORD_W    = 32;
  localparam int NORM_W     = 16;
  localparam int Q_W        = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [T_W-1:0]       ONE_Q16       = 17'h10000;
  localparam logic [T_W-1:0]       T_RESET       = 17'd32768;
  localparam logic [DEG_W-1:0]     DEG_RESET     = 4'd3;
  localparam logic [3:0]           TOP_BIT       = 4'd14;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARAM_T   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_EN = 2'd2;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_ROW,
    ST_NORM,
    ST_SHIFT,
    ST_SQUARE,
    ST_BIT_SQ,
    ST_BIT_CMP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             load_en;
    logic [DEG_W-1:0] load_addr;
    logic             init_en;
    logic             step_en;
    logic             drop_en;
    logic [DEG_W-1:0] row;
    logic [DEG_W-1:0] wr_pos;
    logic             cap_left;
    logic             cap_right;
    logic             tan0_cap;
    logic             tan1_cap;
    logic             norm_init;
    logic             norm_shift;
    logic             sq_en;
    logic             comp_y;
    logic             bit_sq;
    logic             bit_cmp;
    logic [3:0]       bit_idx;
    logic             comp_done;
    logic             set_nvalid;
    logic             emit_en;
    logic [DEG_W-1:0] emit_idx;
  } cmd_t;

  typedef struct packed {
    logic [DEG_W-1:0] deg;
    logic             nen;
    logic             mag_zero;
    logic             mag_high;
    logic             mag_low;
    logic             out_free;
  } stat_t;

endpackage

// ===== sv/bdc_ctrl.sv =====
// Sequencer for the Bezier subdivision block: loading, triangle rows,
// normal iteration and result emission. Depends on bdc_pkg.
module bdc_ctrl #(
  parameter int NPTS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bdc_pkg::stat_t stat,
  output bdc_pkg::cmd_t  cmd
);

  localparam int LW = $clog2(NPTS + 1);

  bdc_pkg::state_t state, state_next;
  logic [LW-1:0]              loaded;
  logic [bdc_pkg::DEG_W-1:0]  row;
  logic [bdc_pkg::DEG_W-1:0]  step;
  logic [3:0]                 bitn;
  logic                       comp;
  logic [bdc_pkg::DEG_W-1:0]  emit;

  logic                       accept;
  logic [LW-1:0]              count;
  logic                       fire;
  logic [4:0]                 m;
  logic                       is_drop;
  logic                       tan_row;

  assign in_ready = (state == bdc_pkg::ST_LOAD);
  assign accept   = in_valid && in_ready;
  assign count    = loaded + LW'(1);
  assign fire     = 5'(count) >= ({1'b0, stat.deg} + 5'd1);
  // Row "row" is built from a previous row of m entries.
  assign m        = {1'b0, stat.deg} + 5'd2 - {1'b0, row};
  assign is_drop  = ({1'b0, step} == (m - 5'd1));
  assign tan_row  = (row == (stat.deg - 4'd1));

  always_comb begin
    state_next = state;
    unique case (state)
      bdc_pkg::ST_LOAD: begin
        if (accept && fire) state_next = bdc_pkg::ST_INIT;
      end
      bdc_pkg::ST_INIT: state_next = bdc_pkg::ST_ROW;
      bdc_pkg::ST_ROW: begin
        if (is_drop && row == stat.deg) begin
          state_next = stat.nen ? bdc_pkg::ST_NORM : bdc_pkg::ST_EMIT;
        end
      end
      bdc_pkg::ST_NORM: state_next = bdc_pkg::ST_SHIFT;
      bdc_pkg::ST_SHIFT: begin
        if (stat.mag_zero) state_next = bdc_pkg::ST_EMIT;
        else if (!stat.mag_high && !stat.mag_low) state_next = bdc_pkg::ST_SQUARE;
      end
      bdc_pkg::ST_SQUARE: state_next = bdc_pkg::ST_BIT_SQ;
      bdc_pkg::ST_BIT_SQ: state_next = bdc_pkg::ST_BIT_CMP;
      bdc_pkg::ST_BIT_CMP: begin
        if (bitn == 4'd0) state_next = comp ? bdc_pkg::ST_EMIT : bdc_pkg::ST_SQUARE;
        else state_next = bdc_pkg::ST_BIT_SQ;
      end
      bdc_pkg::ST_EMIT: begin
        if (stat.out_free && emit == stat.deg) state_next = bdc_pkg::ST_LOAD;
      end
      default: state_next = bdc_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.load_addr = bdc_pkg::DEG_W'(loaded);
    cmd.row       = row;
    cmd.wr_pos    = bdc_pkg::DEG_W'(m - 5'd1);
    cmd.comp_y    = comp;
    cmd.bit_idx   = bitn;
    cmd.emit_idx  = emit;
    unique case (state)
      bdc_pkg::ST_LOAD: cmd.load_en = accept;
      bdc_pkg::ST_INIT: cmd.init_en = 1'b1;
      bdc_pkg::ST_ROW: begin
        cmd.step_en   = !is_drop;
        cmd.drop_en   = is_drop;
        cmd.cap_left  = !is_drop && step == '0;
        cmd.cap_right = !is_drop && ({1'b0, step} == (m - 5'd2));
        cmd.tan0_cap  = !is_drop && tan_row && step == 4'd0;
        cmd.tan1_cap  = !is_drop && tan_row && step == 4'd1;
      end
      bdc_pkg::ST_NORM:   cmd.norm_init  = 1'b1;
      bdc_pkg::ST_SHIFT:  cmd.norm_shift = 1'b1;
      bdc_pkg::ST_SQUARE: cmd.sq_en      = 1'b1;
      bdc_pkg::ST_BIT_SQ: cmd.bit_sq     = 1'b1;
      bdc_pkg::ST_BIT_CMP: begin
        cmd.bit_cmp    = 1'b1;
        cmd.comp_done  = (bitn == 4'd0);
        cmd.set_nvalid = (bitn == 4'd0) && comp;
      end
      bdc_pkg::ST_EMIT: cmd.emit_en = stat.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bdc_pkg::ST_LOAD;
      loaded <= '0;
      row    <= '0;
      step   <= '0;
      bitn   <= '0;
      comp   <= 1'b0;
      emit   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        bdc_pkg::ST_LOAD: begin
          if (accept) loaded <= fire ? '0 : count;
        end
        bdc_pkg::ST_INIT: begin
          row  <= 4'd1;
          step <= '0;
          comp <= 1'b0;
        end
        bdc_pkg::ST_ROW: begin
          if (is_drop) begin
            step <= '0;
            row  <= row + 4'd1;
          end else begin
            step <= step + 4'd1;
          end
        end
        bdc_pkg::ST_SQUARE: bitn <= bdc_pkg::TOP_BIT;
        bdc_pkg::ST_BIT_CMP: begin
          if (bitn == 4'd0) comp <= 1'b1;
          else bitn <= bitn - 4'd1;
        end
        bdc_pkg::ST_EMIT: begin
          if (stat.out_free) emit <= (emit == stat.deg) ? '0 : emit + 4'd1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/bdc_dp.sv =====
// Datapath for the Bezier subdivision block: configuration registers, point
// line, interpolation, normal unit and result register. Depends on bdc_pkg.
module bdc_dp #(
  parameter int NPTS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [bdc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bdc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [bdc_pkg::COORD_W-1:0]   point_x,
  input  logic signed [bdc_pkg::COORD_W-1:0]   point_y,
  input  bdc_pkg::cmd_t                        cmd,
  output bdc_pkg::stat_t                       stat,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [bdc_pkg::DEG_W-1:0]            index,
  output logic signed [bdc_pkg::COORD_W-1:0]   left_x,
  output logic signed [bdc_pkg::COORD_W-1:0]   left_y,
  output logic signed [bdc_pkg::COORD_W-1:0]   right_x,
  output logic signed [bdc_pkg::COORD_W-1:0]   right_y,
  output logic signed [bdc_pkg::COORD_W-1:0]   eval_x,
  output logic signed [bdc_pkg::COORD_W-1:0]   eval_y,
  output logic signed [bdc_pkg::NORM_W-1:0]    normal_x,
  output logic signed [bdc_pkg::NORM_W-1:0]    normal_y,
  output logic                                 normal_valid,
  output logic                                 last
);

  localparam int AW = (NPTS > 1) ? $clog2(NPTS) : 1;
  localparam logic [bdc_pkg::DEG_W-1:0] DMAX = bdc_pkg::DEG_W'(NPTS - 1);
  localparam int Q_W_L = bdc_pkg::Q_W;

  logic [bdc_pkg::DEG_W-1:0] deg_cfg;
  logic [bdc_pkg::T_W-1:0]   t_cfg;
  logic                      nen;
  logic [bdc_pkg::DEG_W-1:0] deg;
  logic [bdc_pkg::T_W-1:0]   t_eff;

  logic signed [31:0] px [NPTS];
  logic signed [31:0] py [NPTS];
  logic signed [31:0] lx [NPTS];
  logic signed [31:0] ly [NPTS];
  logic signed [31:0] rx [NPTS];
  logic signed [31:0] ry [NPTS];
  logic signed [31:0] new_x, new_y;
  logic signed [31:0] t0x, t0y, t1x, t1y;

  logic signed [32:0] dx, dy;
  logic [32:0]        ax, ay, mag;
  logic               dxneg, dyneg;
  logic [32:0]        ssum;
  logic [31:0]        asq;
  logic [31:0]        kk;
  logic [Q_W_L-1:0]   q;
  logic [Q_W_L-1:0]   qx, qy;
  logic               nvalid;
  logic [Q_W_L-1:0]   cand;
  logic [15:0]        kval;
  logic [64:0]        lhs;
  logic               take;
  logic [Q_W_L-1:0]   qfin;
  logic               fin;

  function automatic logic signed [31:0] lerp(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input logic [bdc_pkg::T_W-1:0] t);
    logic signed [32:0] d;
    logic signed [51:0] p;
    logic signed [51:0] r;
    // (1-t)*a + t*b equals a + t*(b-a); the rounding bias is added before the floor.
    d = {b[31], b} - {a[31], a};
    p = $signed({1'b0, t}) * d;
    r = p + 52'sd32768;
    lerp = a + 32'(r >>> 16);
  endfunction

  always_comb begin
    if (deg_cfg == '0) deg = 4'd1;
    else if (deg_cfg > DMAX) deg = DMAX;
    else deg = deg_cfg;
  end
  assign t_eff = (t_cfg > bdc_pkg::ONE_Q16) ? bdc_pkg::ONE_Q16 : t_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      deg_cfg <= bdc_pkg::DEG_RESET;
      t_cfg   <= bdc_pkg::T_RESET;
      nen     <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bdc_pkg::CFG_DEGREE:    deg_cfg <= cfg_data[bdc_pkg::DEG_W-1:0];
        bdc_pkg::CFG_PARAM_T:   t_cfg   <= cfg_data;
        bdc_pkg::CFG_NORMAL_EN: nen     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign new_x = lerp(px[0], px[1], t_eff);
  assign new_y = lerp(py[0], py[1], t_eff);

  // Each step consumes the front pair, shifts the line and appends the new
  // entry behind the entries still to be used.
  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      px[AW'(cmd.load_addr)] <= point_x;
      py[AW'(cmd.load_addr)] <= point_y;
    end
    if (cmd.step_en || cmd.drop_en) begin
      for (int k = 0; k < NPTS - 1; k++) begin
        px[k] <= px[k+1];
        py[k] <= py[k+1];
      end
    end
    if (cmd.step_en) begin
      px[AW'(cmd.wr_pos)] <= new_x;
      py[AW'(cmd.wr_pos)] <= new_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_en) begin
      lx[0]          <= px[0];
      ly[0]          <= py[0];
      rx[AW'(deg)]   <= px[AW'(deg)];
      ry[AW'(deg)]   <= py[AW'(deg)];
      t0x            <= px[0];
      t0y            <= py[0];
      t1x            <= px[1];
      t1y            <= py[1];
    end
    if (cmd.cap_left) begin
      lx[AW'(cmd.row)] <= new_x;
      ly[AW'(cmd.row)] <= new_y;
    end
    if (cmd.cap_right) begin
      rx[AW'(deg - cmd.row)] <= new_x;
      ry[AW'(deg - cmd.row)] <= new_y;
    end
    if (cmd.tan0_cap) begin
      t0x <= new_x;
      t0y <= new_y;
    end
    if (cmd.tan1_cap) begin
      t1x <= new_x;
      t1y <= new_y;
    end
  end

  // Normal unit: normalize the tangent, then find each component one
  // quotient bit at a time as the largest q with (2q-1)^2*s <= a^2*2^30.
  assign dx   = {t1x[31], t1x} - {t0x[31], t0x};
  assign dy   = {t1y[31], t1y} - {t0y[31], t0y};
  assign mag  = (ax > ay) ? ax : ay;
  assign cand = q | (Q_W_L'(1) << cmd.bit_idx);
  assign kval = {cand, 1'b0} - 16'd1;
  assign lhs  = 65'(kk) * 65'(ssum);
  assign take = lhs <= 65'({asq, 30'b0});
  assign qfin = take ? cand : q;

  always_ff @(posedge clk) begin
    if (cmd.norm_init) begin
      ax    <= dx[32] ? 33'(-dx) : 33'(dx);
      ay    <= dy[32] ? 33'(-dy) : 33'(dy);
      dxneg <= dx[32];
      dyneg <= dy[32];
    end
    if (cmd.norm_shift) begin
      if (stat.mag_high) begin
        ax <= ax >> 1;
        ay <= ay >> 1;
      end else if (stat.mag_low) begin
        ax <= ax << 1;
        ay <= ay << 1;
      end
    end
    if (cmd.sq_en) begin
      ssum <= 33'(ax[15:0] * ax[15:0]) + 33'(ay[15:0] * ay[15:0]);
      asq  <= cmd.comp_y ? ax[15:0] * ax[15:0] : ay[15:0] * ay[15:0];
      q    <= '0;
    end
    if (cmd.bit_sq) kk <= kval * kval;
    if (cmd.bit_cmp) q <= qfin;
    if (cmd.comp_done) begin
      if (cmd.comp_y) qy <= qfin;
      else qx <= qfin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nvalid <= 1'b0;
    end else if (cmd.init_en) begin
      nvalid <= 1'b0;
    end else if (cmd.set_nvalid) begin
      nvalid <= 1'b1;
    end
  end

  assign stat.deg      = deg;
  assign stat.nen      = nen;
  assign stat.mag_zero = (mag == '0);
  assign stat.mag_high = (mag[32:16] != '0);
  assign stat.mag_low  = (mag[32:15] == '0);
  assign stat.out_free = !out_valid || out_ready;

  assign fin = (cmd.emit_idx == deg);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_en) begin
      index        <= cmd.emit_idx;
      left_x       <= lx[AW'(cmd.emit_idx)];
      left_y       <= ly[AW'(cmd.emit_idx)];
      right_x      <= rx[AW'(cmd.emit_idx)];
      right_y      <= ry[AW'(cmd.emit_idx)];
      eval_x       <= fin ? lx[AW'(cmd.emit_idx)] : '0;
      eval_y       <= fin ? ly[AW'(cmd.emit_idx)] : '0;
      last         <= fin;
      normal_valid <= fin && nvalid;
      if (fin && nvalid) begin
        normal_x <= dyneg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        normal_y <= dxneg ? $signed({1'b0, qy}) : -$signed({1'b0, qy});
      end else begin
        normal_x <= '0;
        normal_y <= '0;
      end
    end
  end

endmodule

// ===== sv/bezier_de_casteljau_subdivide.sv =====
// Top level of the Bezier subdivision block: sequencer plus datapath.
// Depends on bdc_pkg, bdc_ctrl, bdc_dp and the assertion macro header.
//
//   channel  signals                        direction
//   in       in_valid/in_ready, point_x/y   one control point per item
//   out      out_valid/out_ready, index...  one sub-curve point pair per item
//   cfg      cfg_valid/cfg_ready, index     register write, always ready
//
// A point that does not complete a curve is only stored. The last point of a
// degree-n curve starts the triangle steps on one interpolator per axis, then,
// when the normal is enabled, normal iteration (shift normalization and two
// 15-bit quotient searches), then n+1 results; no point is taken meanwhile.
// Reset clears the point count and loads the register defaults; the output
// register holds a result for as long as out_ready stays low.
`include "bezier_de_casteljau_subdivide_assert.svh"

module bezier_de_casteljau_subdivide #(
  parameter int MAX_DEGREE = 15
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [bdc_pkg::COORD_W-1:0]   point_x,
  input  logic signed [bdc_pkg::COORD_W-1:0]   point_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bdc_pkg::DEG_W-1:0]            index,
  output logic signed [bdc_pkg::COORD_W-1:0]   left_x,
  output logic signed [bdc_pkg::COORD_W-1:0]   left_y,
  output logic signed [bdc_pkg::COORD_W-1:0]   right_x,
  output logic signed [bdc_pkg::COORD_W-1:0]   right_y,
  output logic signed [bdc_pkg::COORD_W-1:0]   eval_x,
  output logic signed [bdc_pkg::COORD_W-1:0]   eval_y,
  output logic signed [bdc_pkg::NORM_W-1:0]    normal_x,
  output logic signed [bdc_pkg::NORM_W-1:0]    normal_y,
  output logic                                 normal_valid,
  output logic                                 last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bdc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bdc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // The degree register is four bits wide, so no curve has more than 16 points.
  localparam int NPTS = ((MAX_DEGREE > 15) ? 15 : MAX_DEGREE) + 1;

  bdc_pkg::cmd_t  cmd;
  bdc_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  bdc_ctrl #(.NPTS(NPTS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bdc_dp #(.NPTS(NPTS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .point_x      (point_x),
    .point_y      (point_y),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .index        (index),
    .left_x       (left_x),
    .left_y       (left_y),
    .right_x      (right_x),
    .right_y      (right_y),
    .eval_x       (eval_x),
    .eval_y       (eval_y),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_valid (normal_valid),
    .last         (last)
  );

  `BDC_ASSERT_IMPL(a_last_index, out_valid && last, index == stat.deg, "last item index is not the degree")
  `BDC_ASSERT_IMPL(a_normal_on_last, out_valid && normal_valid, last, "normal flagged on a non-final item")
  `BDC_ASSERT_IMPL(a_eval_zero, out_valid && !last, (eval_x == 0) && (eval_y == 0) && (normal_x == 0), "final-only fields set early")
  `BDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(index) && $stable(left_x), "waiting item changed")

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for bezier_de_casteljau_subdivide: drives control points
// and register writes and checks every sub-curve result. Depends on bdc_pkg.
module testbench;
  import bdc_pkg::*;

  typedef struct {
    logic [3:0]  idx;
    logic [31:0] lx, ly, rx, ry, ex, ey;
    logic [15:0] nx, ny;
    logic        nv, lst;
  } subpt_t;

  typedef struct {
    logic [31:0] x, y;
  } point_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_ready;
  logic signed [31:0] point_x = 0, point_y = 0;
  logic out_valid, out_ready = 0;
  logic [3:0] index;
  logic signed [31:0] left_x, left_y, right_x, right_y, eval_x, eval_y;
  logic signed [15:0] normal_x, normal_y;
  logic normal_valid, last;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [CFG_DATA_W-1:0] cfg_data = 0;

  bezier_de_casteljau_subdivide dut (.*);

  always #6 clk = ~clk;

  // Predictor state and register copies.
  logic [31:0] store_x[16], store_y[16];
  logic [4:0] loaded = 0;
  logic [3:0] reg_deg = DEG_RESET;
  logic [16:0] reg_t = T_RESET;
  logic reg_nen = 1;

  point_t pending_pts[$];
  subpt_t expected_pts[$];
  int snd_idle = 0, rcv_idle = 0;
  int errors = 0, n_curves = 0, n_results = 0, n_points = 0, cycles = 0;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch on %s: got %h, expected %h (result %0d)", what, got, want,
             n_results);
  endtask

  function automatic longint lerp(longint a, longint b, logic [16:0] t);
    longint v;
    v = longint'(65536 - int'(t)) * a + longint'(t) * b + 32768;
    return v >>> 16;
  endfunction

  // round(16384*a/sqrt(s)) by bisection on the odd half-steps.
  function automatic bit [63:0] unit_len(bit [63:0] a, bit [63:0] s);
    bit [63:0] lo, hi, mid, k, rhs;
    lo = 0;
    hi = 16384;
    rhs = (a * a) << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      k = 2 * mid - 1;
      if (k * k * s <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  task automatic take_point(logic [31:0] px, logic [31:0] py);
    int d;
    logic [16:0] t;
    longint tx[16][16], ty[16][16];
    longint dx, dy, nx, ny;
    bit [63:0] ax, ay, m, s;
    logic nv;
    subpt_t r;
    d = (reg_deg == 0) ? 1 : reg_deg;
    t = (reg_t > ONE_Q16) ? ONE_Q16 : reg_t;
    nx = 0;
    ny = 0;
    nv = 0;
    if (loaded < 16) begin
      store_x[loaded] = px;
      store_y[loaded] = py;
    end
    loaded = loaded + 1;
    if (loaded < d + 1) return;
    loaded = 0;
    n_curves++;
    for (int j = 0; j <= d; j++) begin
      tx[0][j] = longint'($signed(store_x[j]));
      ty[0][j] = longint'($signed(store_y[j]));
    end
    for (int i = 1; i <= d; i++)
      for (int j = 0; j + i <= d; j++) begin
        tx[i][j] = lerp(tx[i-1][j], tx[i-1][j+1], t);
        ty[i][j] = lerp(ty[i-1][j], ty[i-1][j+1], t);
      end
    if (reg_nen) begin
      dx = tx[d-1][1] - tx[d-1][0];
      dy = ty[d-1][1] - ty[d-1][0];
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      m = ax > ay ? ax : ay;
      if (m != 0) begin
        while (m >= 65536) begin
          m >>= 1; ax >>= 1; ay >>= 1;
        end
        while (m < 32768) begin
          m <<= 1; ax <<= 1; ay <<= 1;
        end
        s = ax * ax + ay * ay;
        nx = longint'(unit_len(ay, s));
        ny = longint'(unit_len(ax, s));
        if (dy < 0) nx = -nx;
        if (dx >= 0) ny = -ny;
        nv = 1;
      end
    end
    for (int j = 0; j <= d; j++) begin
      r.idx = 4'(j);
      r.lx = tx[j][0][31:0];
      r.ly = ty[j][0][31:0];
      r.rx = tx[d-j][j][31:0];
      r.ry = ty[d-j][j][31:0];
      r.lst = (j == d);
      r.ex = r.lst ? tx[d][0][31:0] : 0;
      r.ey = r.lst ? ty[d][0][31:0] : 0;
      r.nx = r.lst ? nx[15:0] : 0;
      r.ny = r.lst ? ny[15:0] : 0;
      r.nv = r.lst ? nv : 0;
      expected_pts.push_back(r);
    end
  endtask

  // Driver: payload holds until accepted.
  always @(posedge clk) begin
    point_t p;
    logic nv;
    if (!rst) begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        take_point(point_x, point_y);
        n_points++;
        nv = 0;
      end
      if (!nv && pending_pts.size() > 0 && $urandom_range(99) >= snd_idle) begin
        p = pending_pts.pop_front();
        point_x <= p.x;
        point_y <= p.y;
        nv = 1;
      end
      in_valid <= nv;
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    subpt_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_pts.size() == 0) begin
          errors++;
          $display("unexpected result, index %0d", index);
        end else begin
          e = expected_pts.pop_front();
          if (index !== e.idx) report("index", index, e.idx);
          if (left_x !== e.lx) report("left_x", left_x, e.lx);
          if (left_y !== e.ly) report("left_y", left_y, e.ly);
          if (right_x !== e.rx) report("right_x", right_x, e.rx);
          if (right_y !== e.ry) report("right_y", right_y, e.ry);
          if (eval_x !== e.ex) report("eval_x", eval_x, e.ex);
          if (eval_y !== e.ey) report("eval_y", eval_y, e.ey);
          if (normal_x !== e.nx) report("normal_x", normal_x, e.nx);
          if (normal_y !== e.ny) report("normal_y", normal_y, e.ny);
          if (normal_valid !== e.nv) report("normal_valid", normal_valid, e.nv);
          if (last !== e.lst) report("last", last, e.lst);
        end
        n_results++;
      end
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 600000) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // One write per call; the valid is dropped before the next one.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      CFG_DEGREE:    reg_deg = val[3:0];
      CFG_PARAM_T:   reg_t = val;
      CFG_NORMAL_EN: reg_nen = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Waits until the block has nothing left to do; the tail covers a full run.
  task automatic drain();
    while (pending_pts.size() > 0 || in_valid || expected_pts.size() > 0)
      @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 2000) - 1000;
      3: return $urandom_range(0, 32'h3fffff) - 32'h200000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_point(logic [31:0] x, logic [31:0] y);
    point_t p;
    p.x = x;
    p.y = y;
    pending_pts.push_back(p);
  endtask

  task automatic add_curve(int npts);
    for (int i = 0; i < npts; i++) add_point(rand_coord(), rand_coord());
  endtask

  initial begin
    int deg;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part at reset settings: extreme corners, then a flat curve.
    add_point(32'h7fffffff, 32'h80000000);
    add_point(32'h80000000, 32'h7fffffff);
    add_point(32'h00000000, 32'hffffffff);
    add_point(32'hffffffff, 32'h00000001);
    for (int i = 0; i < 4; i++) add_point(32'h12345678, 32'h87654321);
    drain();
    // Degree zero acts as degree one; t at zero.
    cfg_write(CFG_DEGREE, 0);
    cfg_write(CFG_PARAM_T, 0);
    add_point(32'h00010000, 32'h00020000);
    add_point(32'hfff00000, 32'h00300000);
    drain();
    // Degree fifteen with t saturating above one, normal off.
    cfg_write(CFG_DEGREE, 15);
    cfg_write(CFG_PARAM_T, 17'h1ffff);
    cfg_write(CFG_NORMAL_EN, 0);
    cfg_write(2'd3, 17'h1ffff);
    add_curve(16);
    drain();
    // Shrinking the degree after four points fires on the next point.
    cfg_write(CFG_NORMAL_EN, 1);
    cfg_write(CFG_PARAM_T, ONE_Q16);
    cfg_write(CFG_DEGREE, 5);
    add_curve(4);
    drain();
    cfg_write(CFG_DEGREE, 2);
    add_curve(1);
    drain();

    // Random part: the idling mix changes after each third of the items.
    for (int ph = 0; ph < 30; ph++) begin
      if (ph == 0) begin snd_idle = 28; rcv_idle = 82; end
      if (ph == 10) begin snd_idle = 82; rcv_idle = 28; end
      if (ph == 20) begin snd_idle = 0; rcv_idle = 0; end
      deg = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 4);
      cfg_write(CFG_DEGREE, deg);
      case ($urandom_range(3))
        0: cfg_write(CFG_PARAM_T, $urandom_range(0, 1) ? ONE_Q16 : 17'd0);
        1: cfg_write(CFG_PARAM_T, $urandom_range(65537, 131071));
        default: cfg_write(CFG_PARAM_T, $urandom_range(0, 65536));
      endcase
      cfg_write(CFG_NORMAL_EN, $urandom_range(3) != 0);
      if (deg == 0) deg = 1;
      for (int c = 0; c < 2; c++) begin
        if ($urandom_range(7) == 0) begin
          // Degenerate curve: repeated point gives a zero tangent.
          add_point(32'h00400000, 32'hffc00000);
          for (int i = 0; i < deg; i++) add_point(32'h00400000, 32'hffc00000);
        end else add_curve(deg + 1);
      end
      drain();
    end

    $display("Checked %0d curves from %0d points, %0d results compared.",
             n_curves, n_points, n_results);
    $display("Degrees 0 to 15, t from 0 past one, normal on and off were exercised.");
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
